// ===== hdl/gdd_pkg.sv =====
// Shared types, constants and calendar tables for the Gregorian date difference block.
package gdd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned CodeW  = 3;

  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  // floor(v / 100) == (v * Div100Mul) >> Div100Shift for every v below 2**YearW.
  localparam logic [12:0] Div100Mul   = 13'd5243;
  localparam int unsigned Div100Shift = 19;
  localparam int unsigned ProdW       = YearW + 13;
  localparam int unsigned QuotW       = 8;

  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMax = 4'd12;

  typedef enum logic [CodeW-1:0] {
    ErrOk    = 3'd0,
    ErrZero  = 3'd1,
    ErrRange = 3'd2,
    ErrOrder = 3'd3,
    ErrDay   = 3'd4
  } err_e;

  typedef struct packed {
    logic en1;
    logic en2;
  } stage_en_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before(input logic [MonthW-1:0] m);
    logic [8:0] n;
    case (m)
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/gdd_ordinal.sv =====
// Two-stage ordinal day number and day-of-month check for one date.
module gdd_ordinal (
  input  logic                             clk_i,
  input  gdd_pkg::stage_en_t               en_i,
  input  logic [gdd_pkg::YearW-1:0]        year_i,
  input  logic [gdd_pkg::MonthW-1:0]       month_i,
  input  logic [gdd_pkg::DayW-1:0]         day_i,
  output logic [gdd_pkg::CountW-1:0]       ordinal_o,
  output logic                             day_bad_o
);

  logic [gdd_pkg::YearW-1:0]  p;
  logic [gdd_pkg::ProdW-1:0]  prod_p, prod_y;
  logic [22:0]                p365_full;

  logic [gdd_pkg::YearW-1:0]  y_q, p_q;
  logic [gdd_pkg::MonthW-1:0] m_q;
  logic [gdd_pkg::DayW-1:0]   d_q;
  logic [gdd_pkg::CountW-1:0] p365_q;
  logic [gdd_pkg::QuotW-1:0]  q100p_q, q100y_q;

  logic [gdd_pkg::YearW-1:0]  rem100;
  logic                       leap;
  logic [gdd_pkg::DayW-1:0]   mlen;
  logic [gdd_pkg::CountW-1:0] ordinal_d;

  logic [gdd_pkg::CountW-1:0] ordinal_q;
  logic                       day_bad_q;

  assign p         = year_i - gdd_pkg::YearW'(1);
  assign prod_p    = gdd_pkg::ProdW'(p) * gdd_pkg::ProdW'(gdd_pkg::Div100Mul);
  assign prod_y    = gdd_pkg::ProdW'(year_i) * gdd_pkg::ProdW'(gdd_pkg::Div100Mul);
  assign p365_full = 23'(p) * 23'd365;

  always_ff @(posedge clk_i) begin
    if (en_i.en1) begin
      y_q     <= year_i;
      p_q     <= p;
      m_q     <= month_i;
      d_q     <= day_i;
      p365_q  <= p365_full[gdd_pkg::CountW-1:0];
      q100p_q <= prod_p[gdd_pkg::Div100Shift +: gdd_pkg::QuotW];
      q100y_q <= prod_y[gdd_pkg::Div100Shift +: gdd_pkg::QuotW];
    end
  end

  assign rem100 = y_q - gdd_pkg::YearW'(gdd_pkg::YearW'(q100y_q) * gdd_pkg::YearW'(100));
  assign leap   = (y_q[1:0] == 2'b00) && ((rem100 != '0) || (q100y_q[1:0] == 2'b00));
  assign mlen   = gdd_pkg::month_len(m_q)
                + gdd_pkg::DayW'((m_q == gdd_pkg::MonthFeb) && leap);

  assign ordinal_d = p365_q
                   + gdd_pkg::CountW'(p_q >> 2)
                   - gdd_pkg::CountW'(q100p_q)
                   + gdd_pkg::CountW'(q100p_q >> 2)
                   + gdd_pkg::CountW'(gdd_pkg::days_before(m_q))
                   + gdd_pkg::CountW'(leap && (m_q > gdd_pkg::MonthFeb))
                   + gdd_pkg::CountW'(d_q);

  always_ff @(posedge clk_i) begin
    if (en_i.en2) begin
      ordinal_q <= ordinal_d;
      day_bad_q <= d_q > mlen;
    end
  end

  assign ordinal_o = ordinal_q;
  assign day_bad_o = day_bad_q;

endmodule

// ===== hdl/gregorian_date_difference.sv =====
// Top level of the Gregorian date difference block: validation, ordinals and day counts.
//
//   Channel   Direction  Beat contents
//   s_axis    in         one begin/end date pair
//   m_axis    out        error code and both day counts
//
// Each beat passes through the pipeline stages in order: zero, range and order checks with
// the year products, ordinal assembly with the month length, then subtraction and result.
// A new beat is accepted every cycle while the output side keeps up.
// A stall at the output holds each stage in place; empty stages still fill.
// Reset clears only the stage valid bits.
module gregorian_date_difference #(
  parameter int unsigned MAX_YEAR = 9999
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // begin_year[13:0], begin_month[17:14], begin_day[22:18],
  // end_year[36:23], end_month[40:37], end_day[45:41], zero fill[47:46]
  input  logic [gdd_pkg::InDataW-1:0]    s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // error_code[2:0], days_inclusive[24:3], days_exclusive[46:25], zero fill[47]
  output logic [gdd_pkg::OutDataW-1:0]   m_axis_tdata_o
);

  localparam logic [15:0] MaxYear = 16'(MAX_YEAR);

  logic [gdd_pkg::YearW-1:0]  by, ey;
  logic [gdd_pkg::MonthW-1:0] bm, em;
  logic [gdd_pkg::DayW-1:0]   bd, ed;

  assign by = s_axis_tdata_i[13:0];
  assign bm = s_axis_tdata_i[17:14];
  assign bd = s_axis_tdata_i[22:18];
  assign ey = s_axis_tdata_i[36:23];
  assign em = s_axis_tdata_i[40:37];
  assign ed = s_axis_tdata_i[45:41];

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  gdd_pkg::stage_en_t en;

  assign rdy3   = !v3_q || m_axis_tready_i;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign en.en1 = rdy1;
  assign en.en2 = rdy2;
  assign s_axis_tready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  logic zero_d, range_d, order_d;
  logic zero1_q, range1_q, order1_q;
  logic zero2_q, range2_q, order2_q;

  assign zero_d  = (by == '0) || (bm == '0) || (bd == '0)
                || (ey == '0) || (em == '0) || (ed == '0);
  assign range_d = (bm > gdd_pkg::MonthMax) || (em > gdd_pkg::MonthMax)
                || (16'(by) > MaxYear) || (16'(ey) > MaxYear);
  assign order_d = (ey < by) || ((ey == by) && ((em < bm) || ((em == bm) && (ed < bd))));

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      zero1_q  <= zero_d;
      range1_q <= range_d;
      order1_q <= order_d;
    end
    if (rdy2) begin
      zero2_q  <= zero1_q;
      range2_q <= range1_q;
      order2_q <= order1_q;
    end
  end

  logic [gdd_pkg::CountW-1:0] ord_b, ord_e;
  logic                       day_bad_b, day_bad_e;

  gdd_ordinal u_ord_begin (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (by),
    .month_i   (bm),
    .day_i     (bd),
    .ordinal_o (ord_b),
    .day_bad_o (day_bad_b)
  );

  gdd_ordinal u_ord_end (
    .clk_i     (clk_i),
    .en_i      (en),
    .year_i    (ey),
    .month_i   (em),
    .day_i     (ed),
    .ordinal_o (ord_e),
    .day_bad_o (day_bad_e)
  );

  gdd_pkg::err_e              code_d;
  logic [gdd_pkg::CountW-1:0] diff, incl_d, excl_d;

  always_comb begin
    if (zero2_q) begin
      code_d = gdd_pkg::ErrZero;
    end else if (range2_q) begin
      code_d = gdd_pkg::ErrRange;
    end else if (order2_q) begin
      code_d = gdd_pkg::ErrOrder;
    end else if (day_bad_b || day_bad_e) begin
      code_d = gdd_pkg::ErrDay;
    end else begin
      code_d = gdd_pkg::ErrOk;
    end
  end

  assign diff   = ord_e - ord_b;
  assign excl_d = (code_d == gdd_pkg::ErrOk) ? diff : '0;
  assign incl_d = (code_d == gdd_pkg::ErrOk) ? diff + gdd_pkg::CountW'(1) : '0;

  gdd_pkg::err_e              code_q;
  logic [gdd_pkg::CountW-1:0] incl_q, excl_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      code_q <= code_d;
      incl_q <= incl_d;
      excl_q <= excl_d;
    end
  end

  assign m_axis_tvalid_o = v3_q;
  assign m_axis_tdata_o  = {1'b0, excl_q, incl_q, code_q};

endmodule

// ===== hdl/gdd_checker.sv =====
// Port-level assertions for the Gregorian date difference block, with their bind.
module gdd_props (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_tvalid_i,
  input logic                          out_tready_i,
  input logic [gdd_pkg::OutDataW-1:0]  out_tdata_i
);

  logic [gdd_pkg::CodeW-1:0]  code;
  logic [gdd_pkg::CountW-1:0] incl, excl;

  assign code = out_tdata_i[2:0];
  assign incl = out_tdata_i[24:3];
  assign excl = out_tdata_i[46:25];

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tvalid_i && !out_tready_i |=> out_tvalid_i)
    else $error("Output beat dropped while stalled.");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tvalid_i && !out_tready_i |=> $stable(out_tdata_i))
    else $error("Output beat changed while stalled.");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tvalid_i |-> (code <= gdd_pkg::ErrDay))
    else $error("Error code out of range.");

  a_zero_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tvalid_i && (code != gdd_pkg::ErrOk) |-> (incl == '0) && (excl == '0))
    else $error("Nonzero day count with an error code.");

  a_incl_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_tvalid_i && (code == gdd_pkg::ErrOk) |->
      (incl == excl + gdd_pkg::CountW'(1)))
    else $error("Inclusive count is not exclusive count plus one.");

endmodule

bind gregorian_date_difference gdd_props u_gdd_props (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_tvalid_i (m_axis_tvalid_o),
  .out_tready_i (m_axis_tready_i),
  .out_tdata_i  (m_axis_tdata_o)
);

// ===== test/gdd_checker.sv =====
// Checker for the date difference block: predicts each result beat and compares it.
module gdd_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_tvalid_i,
  input  logic                         in_tready_i,
  input  logic [gdd_pkg::InDataW-1:0]  in_tdata_i,
  input  logic                         out_tvalid_i,
  input  logic                         out_tready_i,
  input  logic [gdd_pkg::OutDataW-1:0] out_tdata_i,
  output int                           fail_count_o,
  output int                           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  localparam int unsigned LastYear = 9999;
  localparam int unsigned ReportLimit = 10;

  localparam int unsigned DaysInMonth [0:12] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30,
                                                 31};
  localparam int unsigned DaysAhead [0:12] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304,
                                               334};

  typedef struct {
    err_e              code;
    logic [CountW-1:0] with_first;
    logic [CountW-1:0] without_first;
  } date_span_t;

  date_span_t span_due_q[$];
  int         fails = 0;

  function automatic bit leap_year(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_days(int unsigned y, int unsigned m);
    return DaysInMonth[m] + ((m == 2 && leap_year(y)) ? 1 : 0);
  endfunction

  function automatic int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
    int unsigned p;
    int unsigned n;
    p = y - 1;
    n = 365 * p + p / 4 - p / 100 + p / 400 + DaysAhead[m];
    if (m > 2 && leap_year(y)) begin
      n = n + 1;
    end
    return n + d;
  endfunction

  function automatic date_span_t predict_span(logic [InDataW-1:0] beat);
    int unsigned by, bm, bd, ey, em, ed;
    int unsigned gap;
    date_span_t  s;
    by = beat[13:0];
    bm = beat[17:14];
    bd = beat[22:18];
    ey = beat[36:23];
    em = beat[40:37];
    ed = beat[45:41];
    s.with_first    = '0;
    s.without_first = '0;
    if (by == 0 || bm == 0 || bd == 0 || ey == 0 || em == 0 || ed == 0) begin
      s.code = ErrZero;
    end else if (bm > 12 || em > 12 || by > LastYear || ey > LastYear) begin
      s.code = ErrRange;
    end else if (ey < by || (ey == by && (em < bm || (em == bm && ed < bd)))) begin
      s.code = ErrOrder;
    end else if (bd > month_days(by, bm) || ed > month_days(ey, em)) begin
      s.code = ErrDay;
    end else begin
      s.code          = ErrOk;
      gap             = day_number(ey, em, ed) - day_number(by, bm, bd);
      s.with_first    = CountW'(gap + 1);
      s.without_first = CountW'(gap);
    end
    return s;
  endfunction

  always @(posedge clk_i) begin
    date_span_t want;
    logic [CodeW-1:0]  got_code;
    logic [CountW-1:0] got_with;
    logic [CountW-1:0] got_without;
    if (rst_ni) begin
      if (in_tvalid_i && in_tready_i) begin
        span_due_q.push_back(predict_span(in_tdata_i));
      end
      if (out_tvalid_i && out_tready_i) begin
        got_code    = out_tdata_i[2:0];
        got_with    = out_tdata_i[24:3];
        got_without = out_tdata_i[46:25];
        if (span_due_q.size() == 0) begin
          fails = fails + 1;
          if (fails <= ReportLimit) begin
            $display("%0t: result beat with nothing outstanding: code %0d incl %0d excl %0d",
                     $realtime, got_code, got_with, got_without);
          end
        end else begin
          want = span_due_q.pop_front();
          if (got_code != want.code || got_with != want.with_first ||
              got_without != want.without_first) begin
            fails = fails + 1;
            if (fails <= ReportLimit) begin
              $display("%0t: mismatch: code %0d/%0d incl %0d/%0d excl %0d/%0d (expected/actual)",
                       $realtime, want.code, got_code, want.with_first, got_with,
                       want.without_first, got_without);
            end
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= span_due_q.size();
    end
  end

endmodule

// ===== test/tb_gregorian_date_difference.sv =====
// Testbench top for the date difference block: clock, reset, stimulus and verdict.
module tb_gregorian_date_difference;
  timeunit 1ns;
  timeprecision 1ps;

  import gdd_pkg::*;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } cal_date_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic hold_start = 1'b0;
  logic hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  gregorian_date_difference dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata)
  );

  gdd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tready_i (s_axis_tready),
    .in_tdata_i  (s_axis_tdata),
    .out_tvalid_i(m_axis_tvalid),
    .out_tready_i(m_axis_tready),
    .out_tdata_i (m_axis_tdata),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // A long hold-off lets the pipeline fill and push back on the input side.
  initial begin
    wait (hold_start);
    hold_off = 1'b1;
    repeat (300) @(negedge clk_i);
    hold_off = 1'b0;
  end

  always @(negedge clk_i) begin
    if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic cal_date_t mk_date(int y, int m, int d);
    cal_date_t c;
    c.year  = YearW'(y);
    c.month = MonthW'(m);
    c.day   = DayW'(d);
    return c;
  endfunction

  function automatic cal_date_t rand_date();
    return mk_date($urandom_range(1, 9999), $urandom_range(1, 12), $urandom_range(1, 28));
  endfunction

  task automatic send_beat(input logic [InDataW-1:0] beat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= beat;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic send_dates(input cal_date_t b, input cal_date_t e);
    send_beat({2'b00, e, b});
  endtask

  task automatic run_random(input int count);
    cal_date_t   b;
    cal_date_t   e;
    cal_date_t   t;
    int          pick;
    logic [31:0] noise;
    repeat (count) begin
      b = rand_date();
      e = rand_date();
      if ($urandom_range(1) == 1) begin
        e.year = (b.year > 9996) ? b.year : b.year + YearW'($urandom_range(0, 3));
      end
      if ($urandom_range(3) == 0) begin
        e.year  = b.year;
        e.month = b.month;
      end
      if ({e.year, e.month, e.day} < {b.year, b.month, b.day}) begin
        t = b;
        b = e;
        e = t;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
      end else if (pick < 68) begin
        if ($urandom_range(1) == 1) begin
          b.day = DayW'($urandom_range(28, 31));
        end else begin
          e.day = DayW'($urandom_range(28, 31));
        end
      end else if (pick < 76) begin
        t = b;
        b = e;
        e = t;
      end else if (pick < 88) begin
        case ($urandom_range(7))
          0: b.year = '0;
          1: e.month = '0;
          2: b.day = '0;
          3: e.year = YearW'($urandom_range(10000, 16383));
          4: b.month = MonthW'($urandom_range(13, 15));
          5: e.day = '0;
          6: b.year = YearW'($urandom_range(10000, 16383));
          default: e.month = MonthW'($urandom_range(13, 15));
        endcase
      end else begin
        noise = $urandom;
        b = noise[22:0];
        noise = $urandom;
        e = noise[22:0];
      end
      send_dates(b, e);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_dates(mk_date(1, 1, 1), mk_date(1, 1, 1));
    send_dates(mk_date(1, 1, 1), mk_date(9999, 12, 31));
    send_dates(mk_date(9999, 12, 31), mk_date(9999, 12, 31));
    send_dates(mk_date(2000, 2, 29), mk_date(2000, 3, 1));
    send_dates(mk_date(1900, 2, 29), mk_date(1900, 3, 1));
    send_dates(mk_date(2004, 2, 29), mk_date(2004, 2, 29));
    send_dates(mk_date(2023, 2, 28), mk_date(2023, 2, 29));
    send_dates(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
    send_dates(mk_date(2020, 4, 31), mk_date(2020, 5, 1));
    send_dates(mk_date(0, 1, 1), mk_date(5, 1, 1));
    send_dates(mk_date(5, 1, 1), mk_date(6, 0, 1));
    send_dates(mk_date(5, 1, 1), mk_date(6, 1, 0));
    send_dates(mk_date(0, 13, 1), mk_date(6, 1, 1));
    send_dates(mk_date(7, 13, 1), mk_date(6, 1, 1));
    send_dates(mk_date(7, 1, 1), mk_date(8, 15, 1));
    send_dates(mk_date(10000, 1, 1), mk_date(10001, 1, 1));
    send_dates(mk_date(1, 1, 1), mk_date(16383, 1, 1));
    send_dates(mk_date(16383, 15, 31), mk_date(16383, 15, 31));
    send_dates(mk_date(2010, 5, 5), mk_date(2009, 6, 6));
    send_dates(mk_date(2010, 5, 5), mk_date(2010, 4, 6));
    send_dates(mk_date(2010, 5, 6), mk_date(2010, 5, 5));
    send_dates(mk_date(2001, 2, 30), mk_date(2001, 2, 29));
    send_dates(mk_date(2001, 2, 1), mk_date(2001, 3, 31));

    hold_start = 1'b1;
    run_random(232);

    send_idle_pct  = 50;
    recv_stall_pct = 0;
    run_random(232);

    send_idle_pct  = 0;
    recv_stall_pct = 50;
    run_random(232);

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    run_random(232);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== gregorian_date_difference.f =====
hdl/gdd_pkg.sv
hdl/gdd_ordinal.sv
hdl/gregorian_date_difference.sv
hdl/gdd_checker.sv
test/gdd_checker.sv
test/tb_gregorian_date_difference.sv
